// ===== design/ffha_pkg.sv =====
// Package for the first-fit heap allocator.
// Holds the table entry type, the cell command codes, the status codes and the
// controller state type. It depends on nothing.
package ffha_pkg;

   typedef struct packed {
      logic        valid;
      logic [31:0] start;
      logic [31:0] size;
   } free_entry_type;

   typedef enum logic [2:0] {
      FC_HOLD,
      FC_LOAD,
      FC_WRITE,
      FC_REMOVE,
      FC_INSERT
   } free_op_type;

   typedef struct packed {
      free_op_type op;
      logic [31:0] start;
      logic [31:0] size;
   } free_cmd_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_ZERO    = 3'd1,
      STAT_NOFIT   = 3'd2,
      STAT_BADADDR = 3'd3,
      STAT_FULL    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ALIGN,
      ST_FIT,
      ST_SLOT,
      ST_ACOMMIT,
      ST_LOOKUP,
      ST_POS,
      ST_FCOMMIT,
      ST_FCOMMIT2,
      ST_LARGEST,
      ST_DONE
   } state_type;

endpackage

// ===== design/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing over one region, one request at a time.
// Allocate: align the size (a mask for a power-of-two ALIGN_BYTES, a reciprocal multiply
// otherwise), scan for the first fitting free block, scan for a free slot, commit and scan for the largest.
// Free: look up the address, scan for its position, commit (with a further step when the block joins
// both neighbours) and scan for the largest. The next request can be accepted in the cycle after the
// result beat. Reset and register writes reload the region through the init state.
module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int ALIGN_BYTES  = 16,
   parameter int FREE_ENTRIES = 16,
   parameter int USED_ENTRIES = 16,
   parameter int ADDR_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [31:0] req_size,
   input  logic [31:0] req_addr,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_block_addr,
   output logic [31:0] rsp_allocated_total,
   output logic [31:0] rsp_free_total,
   output logic [31:0] rsp_largest_free,
   output logic [31:0] rsp_padding_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int FW       = $clog2(FREE_ENTRIES);
   localparam int UW       = (USED_ENTRIES > 1) ? $clog2(USED_ENTRIES) : 1;
   localparam int MAXN     = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
   localparam int CW       = $clog2(MAXN + 1);
   localparam int FCW      = $clog2(FREE_ENTRIES + 1);
   localparam int PAD_W    = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
   localparam int LIM_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam logic [32:0] LIM = 33'd1 << LIM_BITS;
   localparam logic [31:0] BASE_MASK = 32'(LIM - 33'd1);

   state_type        state_ff, state_in;
   logic [31:0]      base_ff, base_in;
   logic [31:0]      hsize_ff, hsize_in;
   logic             type_ff, type_in;
   logic [31:0]      size_ff, size_in;
   logic [31:0]      addr_ff, addr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [FCW-1:0]   fcnt_ff, fcnt_in;
   logic [32:0]      aligned_ff, aligned_in;
   logic [PAD_W-1:0] pad_ff, pad_in;
   logic [FW-1:0]    blk_ff, blk_in;
   logic [UW-1:0]    slot_ff, slot_in;
   logic [2:0]       status_ff, status_in;
   logic [31:0]      out_addr_ff, out_addr_in;
   logic [31:0]      asum_ff, asum_in;
   logic [31:0]      psum_ff, psum_in;
   logic [31:0]      largest_ff, largest_in;
   logic [32:0]      prev_end_ff, prev_end_in;
   logic [31:0]      prev_size_ff, prev_size_in;
   logic             prev_ok_ff, prev_ok_in;
   logic [31:0]      fsize_ff, fsize_in;

   logic [31:0] base_m;
   logic [32:0] room;
   logic [31:0] eff_size;
   logic        cfg_write;

   free_cmd_type   fcmd;
   logic [FW-1:0]  fcmd_idx;
   free_entry_type ent [FREE_ENTRIES];
   free_entry_type cur;

   logic             align_go, align_done;
   logic [32:0]      align_aligned;
   logic [PAD_W-1:0] align_pad;

   logic             u_clear, u_wr, u_clr;
   logic [UW-1:0]    u_idx;
   logic [31:0]      u_wstart, u_wsize;
   logic [PAD_W-1:0] u_wpad;
   logic             u_valid;
   logic [31:0]      u_start, u_size;
   logic [PAD_W-1:0] u_pad;

   logic        scan_end_f, scan_end_u, mprev, mnext;
   logic [32:0] free_end;

   assign base_m    = base_ff & BASE_MASK;
   assign room      = LIM - {1'b0, base_m};
   assign eff_size  = ({1'b0, hsize_ff} < room) ? hsize_ff : room[31:0];
   assign cfg_write = csr_valid && csr_ready;

   genvar gi;
   generate
      for (gi = 0; gi < FREE_ENTRIES; gi++) begin : g_cell
         free_entry_type left_e, right_e;
         if (gi == 0) begin : g_l0
            assign left_e = '0;
         end else begin : g_l
            assign left_e = ent[gi-1];
         end
         if (gi == FREE_ENTRIES - 1) begin : g_rn
            assign right_e = '0;
         end else begin : g_r
            assign right_e = ent[gi+1];
         end
         ffha_free_cell #(
            .FREE_ENTRIES(FREE_ENTRIES),
            .CELL_IDX    (gi)
         ) u_cell (
            .clock  (clock),
            .reset  (reset),
            .cmd    (fcmd),
            .cmd_idx(fcmd_idx),
            .left   (left_e),
            .right  (right_e),
            .entry  (ent[gi])
         );
      end
   endgenerate

   ffha_align #(
      .ALIGN_BYTES(ALIGN_BYTES),
      .PAD_W      (PAD_W)
   ) u_align (
      .clock  (clock),
      .reset  (reset),
      .go     (align_go),
      .size   (size_ff),
      .done   (align_done),
      .aligned(align_aligned),
      .pad    (align_pad)
   );

   ffha_used_table #(
      .USED_ENTRIES(USED_ENTRIES),
      .PAD_W       (PAD_W)
   ) u_used (
      .clock    (clock),
      .reset    (reset),
      .clear_all(u_clear),
      .wr_en    (u_wr),
      .clr_en   (u_clr),
      .wr_idx   (slot_ff),
      .wr_start (u_wstart),
      .wr_size  (u_wsize),
      .wr_pad   (u_wpad),
      .rd_idx   (u_idx),
      .rd_valid (u_valid),
      .rd_start (u_start),
      .rd_size  (u_size),
      .rd_pad   (u_pad)
   );

   assign cur        = ent[cnt_ff[FW-1:0]];
   assign u_idx      = cnt_ff[UW-1:0];
   assign scan_end_f = (cnt_ff == CW'(fcnt_ff));
   assign scan_end_u = (cnt_ff == CW'(USED_ENTRIES));
   assign free_end   = {1'b0, addr_ff} + {1'b0, fsize_ff};
   assign mprev      = prev_ok_ff && (prev_end_ff == {1'b0, addr_ff});
   assign mnext      = !scan_end_f && (free_end == {1'b0, cur.start});

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: begin
            if (cfg_write) begin
               state_in = ST_INIT;
            end else if (start) begin
               if (req_type) begin
                  state_in = ST_LOOKUP;
               end else if (req_size == 32'd0) begin
                  state_in = ST_LARGEST;
               end else begin
                  state_in = ST_ALIGN;
               end
            end
         end
         ST_ALIGN: begin
            if (align_done) begin
               state_in = ST_FIT;
            end
         end
         ST_FIT: begin
            if (scan_end_f) begin
               state_in = ST_LARGEST;
            end else if ({1'b0, cur.size} >= aligned_ff) begin
               state_in = ST_SLOT;
            end
         end
         ST_SLOT: begin
            if (scan_end_u) begin
               state_in = ST_LARGEST;
            end else if (!u_valid) begin
               state_in = ST_ACOMMIT;
            end
         end
         ST_ACOMMIT: state_in = ST_LARGEST;
         ST_LOOKUP: begin
            if (scan_end_u) begin
               state_in = ST_LARGEST;
            end else if (u_valid && u_start == addr_ff) begin
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            if (scan_end_f || cur.start >= addr_ff) begin
               state_in = ST_FCOMMIT;
            end
         end
         ST_FCOMMIT: state_in = (mprev && mnext) ? ST_FCOMMIT2 : ST_LARGEST;
         ST_FCOMMIT2: state_in = ST_LARGEST;
         ST_LARGEST: begin
            if (scan_end_f) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      base_in      = base_ff;
      hsize_in     = hsize_ff;
      type_in      = type_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      fcnt_in      = fcnt_ff;
      aligned_in   = aligned_ff;
      pad_in       = pad_ff;
      blk_in       = blk_ff;
      slot_in      = slot_ff;
      status_in    = status_ff;
      out_addr_in  = out_addr_ff;
      asum_in      = asum_ff;
      psum_in      = psum_ff;
      largest_in   = largest_ff;
      prev_end_in  = prev_end_ff;
      prev_size_in = prev_size_ff;
      prev_ok_in   = prev_ok_ff;
      fsize_in     = fsize_ff;
      fcmd         = '{op: FC_HOLD, start: 32'd0, size: 32'd0};
      fcmd_idx     = blk_ff;
      align_go     = 1'b0;
      u_clear      = 1'b0;
      u_wr         = 1'b0;
      u_clr        = 1'b0;
      u_wstart     = cur.start;
      u_wsize      = aligned_ff[31:0];
      u_wpad       = pad_ff;
      busy         = (state_ff != ST_IDLE);
      csr_ready    = (state_ff == ST_IDLE) && !start;
      rsp_valid    = (state_ff == ST_DONE);

      if (state_in == ST_LARGEST && state_ff != ST_LARGEST) begin
         cnt_in     = '0;
         largest_in = 32'd0;
      end

      case (state_ff)
         ST_INIT: begin
            fcmd    = '{op: FC_LOAD, start: base_m, size: eff_size};
            u_clear = 1'b1;
            fcnt_in = (eff_size != 32'd0) ? FCW'(1) : '0;
            asum_in = 32'd0;
            psum_in = 32'd0;
         end
         ST_IDLE: begin
            if (cfg_write) begin
               if (csr_index) begin
                  hsize_in = csr_data;
               end else begin
                  base_in = csr_data;
               end
            end else if (start) begin
               type_in     = req_type;
               size_in     = req_size;
               addr_in     = req_addr;
               cnt_in      = '0;
               out_addr_in = 32'd0;
               status_in   = STAT_OK;
               if (!req_type && req_size == 32'd0) begin
                  status_in = STAT_ZERO;
               end
            end
         end
         ST_ALIGN: begin
            align_go = (cnt_ff == '0) && !align_done;
            cnt_in   = CW'(1);
            if (align_done) begin
               aligned_in = align_aligned;
               pad_in     = align_pad;
               cnt_in     = '0;
            end
         end
         ST_FIT: begin
            if (scan_end_f) begin
               status_in = STAT_NOFIT;
            end else if ({1'b0, cur.size} >= aligned_ff) begin
               blk_in = cnt_ff[FW-1:0];
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_SLOT: begin
            if (scan_end_u) begin
               status_in = STAT_FULL;
            end else if (!u_valid) begin
               slot_in = cnt_ff[UW-1:0];
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_ACOMMIT: begin
            fcmd_idx = blk_ff;
            if ({1'b0, ent[blk_ff].size} > aligned_ff) begin
               fcmd = '{op: FC_WRITE,
                        start: ent[blk_ff].start + aligned_ff[31:0],
                        size: ent[blk_ff].size - aligned_ff[31:0]};
            end else begin
               fcmd    = '{op: FC_REMOVE, start: 32'd0, size: 32'd0};
               fcnt_in = fcnt_ff - FCW'(1);
            end
            u_wr        = 1'b1;
            u_wstart    = ent[blk_ff].start;
            out_addr_in = ent[blk_ff].start;
            asum_in     = asum_ff + aligned_ff[31:0];
            psum_in     = psum_ff + 32'(pad_ff);
         end
         ST_LOOKUP: begin
            if (scan_end_u) begin
               status_in = STAT_BADADDR;
            end else if (u_valid && u_start == addr_ff) begin
               slot_in    = cnt_ff[UW-1:0];
               fsize_in   = u_size;
               pad_in     = u_pad;
               prev_ok_in = 1'b0;
               cnt_in     = '0;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_POS: begin
            if (!scan_end_f && cur.start < addr_ff) begin
               prev_ok_in   = 1'b1;
               prev_end_in  = {1'b0, cur.start} + {1'b0, cur.size};
               prev_size_in = cur.size;
               cnt_in       = cnt_ff + CW'(1);
            end
         end
         ST_FCOMMIT: begin
            if (mprev) begin
               fcmd_idx = FW'(cnt_ff - CW'(1));
               fcmd     = '{op: FC_WRITE, start: prev_end_ff[31:0] - fsize_ff,
                            size: mnext ? prev_size_ff + fsize_ff + cur.size
                                        : prev_size_ff + fsize_ff};
               fcmd.start = prev_end_ff[31:0] - prev_size_ff;
            end else if (mnext) begin
               fcmd_idx = cnt_ff[FW-1:0];
               fcmd     = '{op: FC_WRITE, start: addr_ff, size: cur.size + fsize_ff};
            end else if (fcnt_ff < FCW'(FREE_ENTRIES)) begin
               fcmd_idx = cnt_ff[FW-1:0];
               fcmd     = '{op: FC_INSERT, start: addr_ff, size: fsize_ff};
               fcnt_in  = fcnt_ff + FCW'(1);
            end
            if (mprev || mnext || fcnt_ff < FCW'(FREE_ENTRIES)) begin
               u_clr   = 1'b1;
               asum_in = asum_ff - fsize_ff;
               psum_in = psum_ff - 32'(pad_ff);
            end else begin
               status_in = STAT_FULL;
            end
         end
         ST_FCOMMIT2: begin
            fcmd_idx = cnt_ff[FW-1:0];
            fcmd     = '{op: FC_REMOVE, start: 32'd0, size: 32'd0};
            fcnt_in  = fcnt_ff - FCW'(1);
         end
         ST_LARGEST: begin
            if (!scan_end_f) begin
               if (cur.size > largest_ff) begin
                  largest_in = cur.size;
               end
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_DONE: begin
            cnt_in = '0;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         base_ff  <= 32'd0;
         hsize_ff <= 32'd65536;
         cnt_ff   <= '0;
         fcnt_ff  <= '0;
         asum_ff  <= 32'd0;
         psum_ff  <= 32'd0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         hsize_ff <= hsize_in;
         cnt_ff   <= cnt_in;
         fcnt_ff  <= fcnt_in;
         asum_ff  <= asum_in;
         psum_ff  <= psum_in;
      end
      type_ff      <= type_in;
      size_ff      <= size_in;
      addr_ff      <= addr_in;
      aligned_ff   <= aligned_in;
      pad_ff       <= pad_in;
      blk_ff       <= blk_in;
      slot_ff      <= slot_in;
      status_ff    <= status_in;
      out_addr_ff  <= out_addr_in;
      largest_ff   <= largest_in;
      prev_end_ff  <= prev_end_in;
      prev_size_ff <= prev_size_in;
      prev_ok_ff   <= prev_ok_in;
      fsize_ff     <= fsize_in;
   end

   assign rsp_status          = status_ff;
   assign rsp_block_addr      = (status_ff == STAT_OK && !type_ff) ? out_addr_ff : 32'd0;
   assign rsp_allocated_total = asum_ff;
   assign rsp_free_total      = eff_size - asum_ff;
   assign rsp_largest_free    = largest_ff;
   assign rsp_padding_total   = psum_ff;

endmodule

// ===== design/ffha_free_cell.sv =====
// One cell of the address-sorted free block chain.
// Holds one free block and takes its neighbor's block on a shift command.
// Depends on ffha_pkg.
module ffha_free_cell
   import ffha_pkg::*;
#(
   parameter int FREE_ENTRIES = 16,
   parameter int CELL_IDX     = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  free_cmd_type                    cmd,
   input  logic [$clog2(FREE_ENTRIES)-1:0] cmd_idx,
   input  free_entry_type                  left,
   input  free_entry_type                  right,
   output free_entry_type                  entry
);

   localparam int IW = $clog2(FREE_ENTRIES);
   localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

   free_entry_type entry_ff;
   free_entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         FC_LOAD: begin
            if (CELL_IDX == 0) begin
               entry_in = '{valid: (cmd.size != 32'd0), start: cmd.start, size: cmd.size};
            end else begin
               entry_in = '0;
            end
         end
         FC_WRITE: begin
            if (MY_IDX == cmd_idx) begin
               entry_in.start = cmd.start;
               entry_in.size  = cmd.size;
            end
         end
         FC_REMOVE: begin
            if (MY_IDX >= cmd_idx) begin
               entry_in = right;
            end
         end
         FC_INSERT: begin
            if (MY_IDX > cmd_idx) begin
               entry_in = left;
            end else if (MY_IDX == cmd_idx) begin
               entry_in = '{valid: 1'b1, start: cmd.start, size: cmd.size};
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.start <= entry_in.start;
      entry_ff.size  <= entry_in.size;
   end

   assign entry = entry_ff;

endmodule

// ===== design/ffha_used_table.sv =====
// Table of live allocations: start, aligned size, padding and a valid bit.
// Written at one slot, read at the scan index. Depends on ffha_pkg only by style.
module ffha_used_table
   import ffha_pkg::*;
#(
   parameter int USED_ENTRIES = 16,
   parameter int PAD_W        = 4
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              clear_all,
   input  logic                                              wr_en,
   input  logic                                              clr_en,
   input  logic [(USED_ENTRIES > 1 ? $clog2(USED_ENTRIES) : 1)-1:0] wr_idx,
   input  logic [31:0]                                       wr_start,
   input  logic [31:0]                                       wr_size,
   input  logic [PAD_W-1:0]                                  wr_pad,
   input  logic [(USED_ENTRIES > 1 ? $clog2(USED_ENTRIES) : 1)-1:0] rd_idx,
   output logic                                              rd_valid,
   output logic [31:0]                                       rd_start,
   output logic [31:0]                                       rd_size,
   output logic [PAD_W-1:0]                                  rd_pad
);

   logic [31:0]      start_ff [USED_ENTRIES];
   logic [31:0]      size_ff  [USED_ENTRIES];
   logic [PAD_W-1:0] pad_ff   [USED_ENTRIES];
   logic [USED_ENTRIES-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end else if (clr_en) begin
         valid_ff[wr_idx] <= 1'b0;
      end
      if (wr_en) begin
         start_ff[wr_idx] <= wr_start;
         size_ff[wr_idx]  <= wr_size;
         pad_ff[wr_idx]   <= wr_pad;
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_start = start_ff[rd_idx];
   assign rd_size  = size_ff[rd_idx];
   assign rd_pad   = pad_ff[rd_idx];

endmodule

// ===== design/ffha_align.sv =====
// Rounds a request size up to the alignment and gives the padding.
// Power-of-two alignments use a mask; others use a reciprocal multiply that registers the products,
// then the quotient, then the remainder and then the padding. Depends on ffha_pkg only by style.
module ffha_align
   import ffha_pkg::*;
#(
   parameter int ALIGN_BYTES = 16,
   parameter int PAD_W       = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [31:0]      size,
   output logic             done,
   output logic [32:0]      aligned,
   output logic [PAD_W-1:0] pad
);

   localparam bit IS_POW2 = (ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0;

   logic             done_ff, done_in;
   logic [32:0]      aligned_ff, aligned_in;
   logic [PAD_W-1:0] pad_ff, pad_in;

   generate
      if (IS_POW2) begin : g_pow2
         logic [31:0] low;
         logic [31:0] pad32;
         always_comb begin
            low        = size & 32'(ALIGN_BYTES - 1);
            pad32      = (32'(ALIGN_BYTES) - low) & 32'(ALIGN_BYTES - 1);
            done_in    = go;
            pad_in     = PAD_W'(pad32);
            aligned_in = {1'b0, size} + {1'b0, pad32};
         end
      end else begin : g_recip
         localparam int LW = $clog2(ALIGN_BYTES);
         localparam int RW = LW + 1;
         localparam logic [RW-1:0] AL = RW'(ALIGN_BYTES);
         localparam longint unsigned MAGIC =
            ((64'd1 << (32 + LW)) / 64'(ALIGN_BYTES)) + 64'd1;
         localparam logic [16:0] M_LO = 17'(MAGIC & 64'h1_FFFF);
         localparam logic [16:0] M_HI = 17'(MAGIC >> 17);
         logic [2:0]    stage_ff, stage_in;
         logic [31:0]   size_ff, size_in;
         logic [48:0]   plo_ff, plo_in;
         logic [48:0]   phi_ff, phi_in;
         logic [31:0]   quo_ff, quo_in;
         logic [RW-1:0] rem_ff, rem_in;
         logic [65:0]   prod;
         logic [31:0]   back;
         logic [RW-1:0] padr;
         always_comb begin
            stage_in   = {stage_ff[1:0], go};
            size_in    = size_ff;
            plo_in     = plo_ff;
            phi_in     = phi_ff;
            quo_in     = quo_ff;
            rem_in     = rem_ff;
            done_in    = stage_ff[2];
            pad_in     = pad_ff;
            aligned_in = aligned_ff;
            prod       = {phi_ff, 17'd0} + {17'd0, plo_ff};
            back       = quo_ff * 32'(ALIGN_BYTES);
            padr       = (rem_ff == '0) ? '0 : AL - rem_ff;
            if (go) begin
               size_in = size;
               plo_in  = 49'(size) * 49'(M_LO);
               phi_in  = 49'(size) * 49'(M_HI);
            end
            if (stage_ff[0]) begin
               quo_in = 32'(prod >> (32 + LW));
            end
            if (stage_ff[1]) begin
               rem_in = RW'(size_ff - back);
            end
            if (stage_ff[2]) begin
               pad_in     = PAD_W'(padr);
               aligned_in = {1'b0, size_ff} + 33'(padr);
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               stage_ff <= '0;
            end else begin
               stage_ff <= stage_in;
            end
            size_ff <= size_in;
            plo_ff  <= plo_in;
            phi_ff  <= phi_in;
            quo_ff  <= quo_in;
            rem_ff  <= rem_in;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      aligned_ff <= aligned_in;
      pad_ff     <= pad_in;
   end

   assign done    = done_ff;
   assign aligned = aligned_ff;
   assign pad     = pad_ff;

endmodule

// ===== design/ffha_checker.sv =====
// Port-level checks for the first-fit heap allocator.
// Watches the top level's ports only and is bound to it below. Depends on ffha_pkg.
module ffha_checker
   import ffha_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_block_addr,
   input logic [31:0] rsp_allocated_total,
   input logic [31:0] rsp_padding_total
);

   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat lasted more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while idle");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_block_addr == 32'd0)
      else $error("address reported on a failed request");

   a_pad_le_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_padding_total <= rsp_allocated_total)
      else $error("padding total exceeds allocated total");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_status         (rsp_status),
   .rsp_block_addr     (rsp_block_addr),
   .rsp_allocated_total(rsp_allocated_total),
   .rsp_padding_total  (rsp_padding_total)
);
